// ===== hw/rtl/launcher_sequencer_with_yaw_aim_macros.svh =====
// Assertion macros for the launcher sequencer with yaw aim.
`ifndef LAUNCHER_SEQUENCER_WITH_YAW_AIM_MACROS_SVH
`define LAUNCHER_SEQUENCER_WITH_YAW_AIM_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define LSYA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("launcher sequencer check failed");
// Next-cycle implication, checked outside reset.
`define LSYA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("launcher sequencer check failed");
`else
`define LSYA_ASSERT_SAME(label, clk, rst, ante, cons)
`define LSYA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/lsya_pkg.sv =====
// Shared types, codes and constants for the launcher sequencer with yaw aim.
`timescale 1ns / 1ps
package lsya_pkg;

  localparam int TIME_WIDTH = 32;

  // Opcodes of an input transaction
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_ESTOP = 2'd3;

  // Yaw modes
  localparam logic [1:0] YAW_MODE_MANUAL = 2'd0;
  localparam logic [1:0] YAW_MODE_VISION = 2'd1;
  localparam logic [1:0] YAW_MODE_GUIDE  = 2'd2;

  // Yaw command kinds
  localparam logic [1:0] YAW_CMD_NONE  = 2'd0;
  localparam logic [1:0] YAW_CMD_SPEED = 2'd1;
  localparam logic [1:0] YAW_CMD_ANGLE = 2'd2;

  // Servo commands
  localparam logic [1:0] SERVO_NONE     = 2'd0;
  localparam logic [1:0] SERVO_STANDARD = 2'd1;
  localparam logic [1:0] SERVO_PREP     = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_YAW_MODE          = 3'd0;
  localparam logic [2:0] REG_SPRING_PREP_TURNS = 3'd1;
  localparam logic [2:0] REG_STEP_TIMEOUT_MS   = 3'd2;
  localparam logic [2:0] REG_SERVO_WAIT_MS     = 3'd3;
  localparam logic [2:0] REG_YAW_DEADBAND      = 3'd4;
  localparam logic [2:0] REG_YAW_GAIN          = 3'd5;
  localparam logic [2:0] REG_YAW_SPEED_LIMIT   = 3'd6;
  localparam logic [2:0] REG_YAW_GUIDE_ANGLE   = 3'd7;

  typedef struct packed {
    logic [1:0]  yaw_mode;
    logic [15:0] spring_prep_turns;
    logic [15:0] step_timeout_ms;
    logic [15:0] servo_wait_ms;
    logic [14:0] yaw_deadband;
    logic [15:0] yaw_gain;
    logic [14:0] yaw_speed_limit;
    logic [15:0] yaw_guide_angle;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    yaw_mode:          YAW_MODE_MANUAL,
    spring_prep_turns: 16'd1280,
    step_timeout_ms:   16'd3000,
    servo_wait_ms:     16'd400,
    yaw_deadband:      15'd5,
    yaw_gain:          16'd256,
    yaw_speed_limit:   15'd1000,
    yaw_guide_angle:   16'd0
  };

endpackage

// ===== hw/rtl/lsya_yaw_aim.sv =====
// Yaw command unit: vision proportional speed or fixed guide angle, or no command in manual mode.
`timescale 1ns / 1ps
module lsya_yaw_aim (
  input  lsya_pkg::cfg_t     cfg,
  input  logic               vision_valid,
  input  logic signed [15:0] vision_error,
  output logic [1:0]         yaw_command,
  output logic signed [15:0] yaw_value
);
  import lsya_pkg::*;

  logic signed [32:0] product;
  logic signed [24:0] speed_raw;
  logic signed [24:0] limit_pos;
  logic signed [24:0] limit_neg;
  logic signed [24:0] speed_clamped;
  logic [16:0]        err_mag;
  logic               in_deadband;

  // Gain is unsigned Q8.8, so a zero sign bit is prefixed before the multiply.
  assign product   = $signed({1'b0, cfg.yaw_gain}) * vision_error;
  // An arithmetic shift gives the floor of the division by 256 for either sign.
  assign speed_raw = product[32:8];
  assign limit_pos = $signed({10'd0, cfg.yaw_speed_limit});
  assign limit_neg = -limit_pos;

  assign err_mag     = vision_error[15] ? 17'(-$signed({vision_error[15], vision_error}))
                                        : {1'b0, vision_error};
  assign in_deadband = err_mag < {2'd0, cfg.yaw_deadband};

  always_comb begin
    if (speed_raw > limit_pos) begin
      speed_clamped = limit_pos;
    end else if (speed_raw < limit_neg) begin
      speed_clamped = limit_neg;
    end else begin
      speed_clamped = speed_raw;
    end
  end

  always_comb begin
    case (cfg.yaw_mode)
      YAW_MODE_VISION: begin
        yaw_command = YAW_CMD_SPEED;
        yaw_value   = (!vision_valid || in_deadband) ? 16'sd0 : speed_clamped[15:0];
      end
      YAW_MODE_GUIDE: begin
        yaw_command = YAW_CMD_ANGLE;
        yaw_value   = $signed(cfg.yaw_guide_angle);
      end
      default: begin
        yaw_command = YAW_CMD_NONE;
        yaw_value   = 16'sd0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/launcher_sequencer_with_yaw_aim.sv =====
// Top level: launcher sequencer with yaw aim, stream ports and register port.
`timescale 1ns / 1ps
// Takes one transaction per clock cycle when not refused and returns exactly
// one result per transaction. An accepted transaction is held in the input
// register and its result is offered from the result register, with all
// sequencing, timing and yaw arithmetic done in the single logic stage between
// them. The input is refused only while the input register holds an item that
// cannot move because the result register is full and not being taken.
// Configuration registers must be written through the register port while no
// transaction is in flight (not enforced); reads return the stored value.
`include "launcher_sequencer_with_yaw_aim_macros.svh"
module launcher_sequencer_with_yaw_aim (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] estop_level, [32:1] now_ms, [33] spring_at_rest, [34] spring_at_prep,
  // [35] vision_valid, [51:36] vision_error, [55:52] zero
  input  logic [55:0] s_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_tuser,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] stop_all, [2:1] servo_command, [3] spring_command_valid,
  // [19:4] spring_target, [21:20] yaw_command, [37:22] yaw_value,
  // [40:38] sequence_step, [41] estop_active, [47:42] zero
  output logic [47:0] m_tdata,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lsya_pkg::*;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_SERVO_STANDARD,
    STEP_SPRING_REST,
    STEP_SPRING_PREP,
    STEP_SERVO_PREP,
    STEP_SPRING_BACK,
    STEP_SERVO_RETURN,
    STEP_DONE
  } step_t;

  cfg_t cfg;

  // Input register
  logic                  in_valid;
  logic [1:0]            in_opcode;
  logic                  in_estop_level;
  logic [TIME_WIDTH-1:0] in_now;
  logic                  in_at_rest;
  logic                  in_at_prep;
  logic                  in_vision_valid;
  logic signed [15:0]    in_vision_error;

  // Sequencer state
  step_t                 launch_step;
  step_t                 launch_step_next;
  logic [TIME_WIDTH-1:0] step_start_time;
  logic [TIME_WIDTH-1:0] step_start_time_next;
  logic                  estop_latched;
  logic                  estop_latched_next;

  // Result register
  logic                  out_stop_all;
  logic [1:0]            out_servo;
  logic                  out_spring_valid;
  logic [15:0]           out_spring_target;
  logic [1:0]            out_yaw_cmd;
  logic signed [15:0]    out_yaw_value;
  logic [2:0]            out_step;
  logic                  out_estop;

  // Values computed for the item in the input register
  logic                  res_stop_all;
  logic [1:0]            res_servo;
  logic                  res_spring_valid;
  logic [15:0]           res_spring_target;
  logic [1:0]            res_yaw_cmd;
  logic signed [15:0]    res_yaw_value;

  logic [1:0]            aim_cmd;
  logic signed [15:0]    aim_value;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  spring_expired;
  logic                  servo_expired;
  logic                  advance;
  logic                  cfg_write;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_YAW_MODE:          cfg.yaw_mode          <= pwdata[1:0];
        REG_SPRING_PREP_TURNS: cfg.spring_prep_turns <= pwdata[15:0];
        REG_STEP_TIMEOUT_MS:   cfg.step_timeout_ms   <= pwdata[15:0];
        REG_SERVO_WAIT_MS:     cfg.servo_wait_ms     <= pwdata[15:0];
        REG_YAW_DEADBAND:      cfg.yaw_deadband      <= pwdata[14:0];
        REG_YAW_GAIN:          cfg.yaw_gain          <= pwdata[15:0];
        REG_YAW_SPEED_LIMIT:   cfg.yaw_speed_limit   <= pwdata[14:0];
        REG_YAW_GUIDE_ANGLE:   cfg.yaw_guide_angle   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_YAW_MODE:          prdata = {30'd0, cfg.yaw_mode};
      REG_SPRING_PREP_TURNS: prdata = {16'd0, cfg.spring_prep_turns};
      REG_STEP_TIMEOUT_MS:   prdata = {16'd0, cfg.step_timeout_ms};
      REG_SERVO_WAIT_MS:     prdata = {16'd0, cfg.servo_wait_ms};
      REG_YAW_DEADBAND:      prdata = {17'd0, cfg.yaw_deadband};
      REG_YAW_GAIN:          prdata = {16'd0, cfg.yaw_gain};
      REG_YAW_SPEED_LIMIT:   prdata = {17'd0, cfg.yaw_speed_limit};
      REG_YAW_GUIDE_ANGLE:   prdata = {16'd0, cfg.yaw_guide_angle};
      default:               prdata = 32'd0;
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_opcode       <= s_tuser;
      in_estop_level  <= s_tdata[0];
      in_now          <= s_tdata[TIME_WIDTH:1];
      in_at_rest      <= s_tdata[33];
      in_at_prep      <= s_tdata[34];
      in_vision_valid <= s_tdata[35];
      in_vision_error <= $signed(s_tdata[51:36]);
    end
  end

  lsya_yaw_aim u_yaw_aim (
    .cfg          (cfg),
    .vision_valid (in_vision_valid),
    .vision_error (in_vision_error),
    .yaw_command  (aim_cmd),
    .yaw_value    (aim_value)
  );

  // Elapsed time wraps with the time counter, so a plain subtraction suffices.
  assign elapsed        = in_now - step_start_time;
  assign spring_expired = elapsed > TIME_WIDTH'(cfg.step_timeout_ms);
  assign servo_expired  = elapsed > TIME_WIDTH'(cfg.servo_wait_ms);

  always_comb begin
    launch_step_next     = launch_step;
    step_start_time_next = step_start_time;
    estop_latched_next   = estop_latched;
    res_stop_all         = 1'b0;
    res_servo            = SERVO_NONE;
    res_spring_valid     = 1'b0;
    res_spring_target    = 16'd0;
    res_yaw_cmd          = YAW_CMD_NONE;
    res_yaw_value        = 16'sd0;

    unique case (in_opcode)
      OP_START: begin
        if (!estop_latched) begin
          launch_step_next = STEP_SERVO_STANDARD;
        end
      end
      OP_STOP: begin
        launch_step_next = STEP_IDLE;
      end
      OP_ESTOP: begin
        estop_latched_next = in_estop_level;
        if (in_estop_level) begin
          res_stop_all     = 1'b1;
          res_servo        = SERVO_STANDARD;
          launch_step_next = STEP_IDLE;
        end
      end
      default: begin
        if (estop_latched) begin
          res_stop_all = 1'b1;
        end else begin
          res_yaw_cmd   = aim_cmd;
          res_yaw_value = aim_value;
          unique case (launch_step)
            STEP_SERVO_STANDARD: begin
              res_servo            = SERVO_STANDARD;
              step_start_time_next = in_now;
              launch_step_next     = STEP_SPRING_REST;
            end
            STEP_SPRING_REST: begin
              res_spring_valid = 1'b1;
              if (in_at_rest || spring_expired) begin
                step_start_time_next = in_now;
                launch_step_next     = STEP_SPRING_PREP;
              end
            end
            STEP_SPRING_PREP: begin
              res_spring_valid  = 1'b1;
              res_spring_target = cfg.spring_prep_turns;
              if (in_at_prep || spring_expired) begin
                step_start_time_next = in_now;
                launch_step_next     = STEP_SERVO_PREP;
              end
            end
            STEP_SERVO_PREP: begin
              res_servo = SERVO_PREP;
              if (servo_expired) begin
                step_start_time_next = in_now;
                launch_step_next     = STEP_SPRING_BACK;
              end
            end
            STEP_SPRING_BACK: begin
              res_spring_valid = 1'b1;
              if (in_at_rest || spring_expired) begin
                step_start_time_next = in_now;
                launch_step_next     = STEP_SERVO_RETURN;
              end
            end
            STEP_SERVO_RETURN: begin
              res_servo = SERVO_STANDARD;
              if (servo_expired) begin
                launch_step_next = STEP_DONE;
              end
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      launch_step     <= STEP_IDLE;
      step_start_time <= '0;
      estop_latched   <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (advance) begin
        launch_step     <= launch_step_next;
        step_start_time <= step_start_time_next;
        estop_latched   <= estop_latched_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stop_all      <= res_stop_all;
      out_servo         <= res_servo;
      out_spring_valid  <= res_spring_valid;
      out_spring_target <= res_spring_target;
      out_yaw_cmd       <= res_yaw_cmd;
      out_yaw_value     <= res_yaw_value;
      out_step          <= launch_step_next;
      out_estop         <= estop_latched_next;
    end
  end

  assign m_tdata = {6'd0, out_estop, out_step, out_yaw_value, out_yaw_cmd,
                    out_spring_target, out_spring_valid, out_servo, out_stop_all};

  // While the emergency stop is latched the sequence can only sit idle.
  `LSYA_ASSERT_SAME(a_estop_idle, clk, rst, estop_latched, launch_step == STEP_IDLE)
  // Every item that leaves the input register lands in the result register.
  `LSYA_ASSERT_NEXT(a_advance_lands, clk, rst, advance, m_tvalid)
  // An item held in the input register is not dropped while the output stalls.
  `LSYA_ASSERT_NEXT(a_input_held, clk, rst, in_valid && !advance, in_valid)
  // A result without a yaw command carries a zero yaw value.
  `LSYA_ASSERT_SAME(a_yaw_none_zero, clk, rst,
                    m_tvalid && out_yaw_cmd == YAW_CMD_NONE, out_yaw_value == 16'sd0)

endmodule
